### rtl/gb5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gb5_pkg;

    localparam int PIX_W        = 24;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 3;
    localparam int TAPS         = 5;
    localparam int STORED_ROWS  = 4;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;
    localparam int CNT_W        = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int FW_W         = 11;
    localparam int FH_W         = 13;
    localparam int WT_W         = 16;
    localparam int ROW_W        = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int NUM_WCLASS   = 6;
    localparam int WCLS_W       = 3;
    localparam int PROD_W       = CH_W + WT_W;
    localparam int ROWSUM_W     = PROD_W + 3;
    localparam int SUM_W        = PROD_W + 5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEAR_EDGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEAR_DIAG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FAR_EDGE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_KNIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FAR_CORNER = 3'd7;

    localparam logic [WCLS_W-1:0] WC_CENTER     = 3'd0;
    localparam logic [WCLS_W-1:0] WC_NEAR_EDGE  = 3'd1;
    localparam logic [WCLS_W-1:0] WC_NEAR_DIAG  = 3'd2;
    localparam logic [WCLS_W-1:0] WC_FAR_EDGE   = 3'd3;
    localparam logic [WCLS_W-1:0] WC_KNIGHT     = 3'd4;
    localparam logic [WCLS_W-1:0] WC_FAR_CORNER = 3'd5;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [WT_W-1:0] W_CENTER_RST     = 16'd13168;
    localparam logic [WT_W-1:0] W_NEAR_EDGE_RST  = 16'd7005;
    localparam logic [WT_W-1:0] W_NEAR_DIAG_RST  = 16'd3726;
    localparam logic [WT_W-1:0] W_FAR_EDGE_RST   = 16'd1054;
    localparam logic [WT_W-1:0] W_KNIGHT_RST     = 16'd561;
    localparam logic [WT_W-1:0] W_FAR_CORNER_RST = 16'd84;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [TAPS-1:0] column_t;
    typedef column_t [TAPS-1:0] window_t;
    typedef logic [NUM_WCLASS-1:0][WT_W-1:0] weights_t;

    // Window is indexed [column slot][row slot]; slot 2 is the center.
    typedef struct packed {
        window_t    win;
        logic [3:0] row_ok;
        logic [3:0] col_ok;
        logic       last;
    } job_t;

    function automatic logic [WCLS_W-1:0] weight_class(input int r, input int c);
        int d;
        d = (r - 2) * (r - 2) + (c - 2) * (c - 2);
        case (d)
            0: return WC_CENTER;
            1: return WC_NEAR_EDGE;
            2: return WC_NEAR_DIAG;
            4: return WC_FAR_EDGE;
            5: return WC_KNIGHT;
            default: return WC_FAR_CORNER;
        endcase
    endfunction

endpackage
`default_nettype wire

### rtl/gb5_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gb5_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,
    input  wire logic                        s_tuser,
    input  wire logic [gb5_pkg::FW_W-1:0]    cfg_width,
    input  wire logic [gb5_pkg::FH_W-1:0]    cfg_height,
    input  wire logic [gb5_pkg::CNT_W-1:0]   q_count,
    output logic                             push,
    output gb5_pkg::job_t                    push_job
);
    import gb5_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LAG_W = WW + 2;
    localparam int KW    = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 2 * MAX_WIDTH + 3);
    localparam int MEM_W = STORED_ROWS * PIX_W;

    logic [WW-1:0]    latw_reg, latw_next;
    logic [ROW_W-1:0] lath_reg, lath_next;
    logic [LAG_W-1:0] lag_reg, lag_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]    st_col_reg, st_col_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [KW-1:0]    j_reg, j_next;
    logic [CW-1:0]    oc_reg, oc_next;
    logic [ROW_W-1:0] or_reg, or_next;
    logic             drain_reg, drain_next;

    logic             b_valid_reg, b_emit_reg, b_hit_reg, b_last_reg;
    logic [CW-1:0]    b_col_reg;
    pixel_t           b_px_reg;
    logic [3:0]       b_rowok_reg, b_colok_reg;
    logic [MEM_W-1:0] rd_reg, fwd_reg;
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    window_t          win_reg, win_next;

    logic [WW-1:0]    w_cfg, w_eff, col_inc, in_inc;
    logic [ROW_W-1:0] h_cfg, h_eff, or_b;
    logic [LAG_W-1:0] lag_cfg, lag_eff;
    logic [CW-1:0]    col_b, oc_b;
    logic [KW-1:0]    k_b, j_b;
    logic             is_flush, start, drain_b, pend, phantom, pix_emit, room;
    logic             accept, step, emit, last, frame_end;
    logic [3:0]       row_ok, col_ok;
    logic [MEM_W-1:0] rdata, wdata;
    column_t          newcol;

    always_comb begin
        if (cfg_width == '0) begin
            w_cfg = WW'(1);
        end else if (int'(cfg_width) > MAX_WIDTH) begin
            w_cfg = WW'(MAX_WIDTH);
        end else begin
            w_cfg = WW'(cfg_width);
        end
        if (cfg_height == '0) begin
            h_cfg = ROW_W'(1);
        end else if (int'(cfg_height) > HEIGHT_LIMIT) begin
            h_cfg = ROW_W'(HEIGHT_LIMIT);
        end else begin
            h_cfg = ROW_W'(cfg_height);
        end
        lag_cfg = LAG_W'({w_cfg, 1'b0}) + LAG_W'(2);
    end

    always_comb begin
        is_flush = s_tuser;
        start    = !is_flush && (in_col_reg == '0) && (in_row_reg == '0);
        w_eff    = start ? w_cfg : latw_reg;
        h_eff    = start ? h_cfg : lath_reg;
        lag_eff  = start ? lag_cfg : lag_reg;
        col_b    = start ? '0 : st_col_reg;
        k_b      = start ? '0 : k_reg;
        j_b      = start ? '0 : j_reg;
        oc_b     = start ? '0 : oc_reg;
        or_b     = start ? '0 : or_reg;
        drain_b  = start ? 1'b0 : drain_reg;
        pend     = drain_b && (or_b < h_eff);
        phantom  = is_flush && pend && (k_b < j_b + KW'(lag_eff));
        pix_emit = k_b >= KW'(lag_eff);
        room     = (int'(q_count) + int'(b_emit_reg)) < QDEPTH;
        s_tready = room && !(s_tvalid && phantom);
        accept   = s_tvalid && s_tready;
        step     = s_tvalid && room && (!is_flush || pend);
        emit     = accept && (is_flush ? pend : pix_emit);
        last     = (WW'(oc_b) == w_eff - WW'(1)) && (or_b == h_eff - ROW_W'(1));
        col_inc  = WW'(col_b) + WW'(1);
        in_inc   = WW'(in_col_reg) + WW'(1);
        frame_end = (in_inc >= w_eff) && (in_row_reg + ROW_W'(1) >= h_eff);

        row_ok[0] = or_b >= ROW_W'(2);
        row_ok[1] = or_b >= ROW_W'(1);
        row_ok[2] = ({1'b0, or_b} + (ROW_W + 1)'(1)) < {1'b0, h_eff};
        row_ok[3] = ({1'b0, or_b} + (ROW_W + 1)'(2)) < {1'b0, h_eff};
        col_ok[0] = oc_b >= CW'(2);
        col_ok[1] = oc_b >= CW'(1);
        col_ok[2] = ((WW + 1)'(oc_b) + (WW + 1)'(1)) < (WW + 1)'(w_eff);
        col_ok[3] = ((WW + 1)'(oc_b) + (WW + 1)'(2)) < (WW + 1)'(w_eff);
    end

    always_comb begin
        latw_next   = latw_reg;
        lath_next   = lath_reg;
        lag_next    = lag_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        st_col_next = st_col_reg;
        k_next      = k_reg;
        j_next      = j_reg;
        oc_next     = oc_reg;
        or_next     = or_reg;
        drain_next  = drain_reg;
        if (step) begin
            st_col_next = (col_inc >= w_eff) ? '0 : CW'(col_inc);
            k_next      = k_b + KW'(1);
        end
        if (accept && !is_flush) begin
            if (start) begin
                latw_next  = w_cfg;
                lath_next  = h_cfg;
                lag_next   = lag_cfg;
                oc_next    = '0;
                or_next    = '0;
                j_next     = '0;
                drain_next = 1'b0;
            end
            if (in_inc >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = CW'(in_inc);
            end
            if (frame_end) begin
                in_row_next = '0;
                drain_next  = 1'b1;
            end
        end
        if (accept && is_flush && drain_b && !pend) begin
            drain_next = 1'b0;
        end
        if (emit) begin
            j_next = j_b + KW'(1);
            if (WW'(oc_b) + WW'(1) >= w_eff) begin
                oc_next = '0;
                or_next = or_b + ROW_W'(1);
            end else begin
                oc_next = oc_b + CW'(1);
            end
            if (last) begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latw_reg    <= WW'(640);
            lath_reg    <= ROW_W'(480);
            lag_reg     <= LAG_W'(1282);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            st_col_reg  <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            oc_reg      <= '0;
            or_reg      <= '0;
            drain_reg   <= 1'b0;
            b_valid_reg <= 1'b0;
            b_emit_reg  <= 1'b0;
        end else begin
            latw_reg    <= latw_next;
            lath_reg    <= lath_next;
            lag_reg     <= lag_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            st_col_reg  <= st_col_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            oc_reg      <= oc_next;
            or_reg      <= or_next;
            drain_reg   <= drain_next;
            b_valid_reg <= step;
            b_emit_reg  <= emit;
        end
    end

    // Each line memory word holds the four pixels above the column, newest row lowest.
    always_comb begin
        rdata     = b_hit_reg ? fwd_reg : rd_reg;
        wdata     = {rdata[MEM_W-PIX_W-1:0], b_px_reg};
        newcol[0] = rdata[4*PIX_W-1 -: PIX_W];
        newcol[1] = rdata[3*PIX_W-1 -: PIX_W];
        newcol[2] = rdata[2*PIX_W-1 -: PIX_W];
        newcol[3] = rdata[PIX_W-1:0];
        newcol[4] = b_px_reg;
        for (int s = 0; s < TAPS - 1; s++) begin
            win_next[s] = win_reg[s+1];
        end
        win_next[TAPS-1] = newcol;
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            rd_reg <= line_mem[col_b];
        end
        if (b_valid_reg) begin
            line_mem[b_col_reg] <= wdata;
            win_reg             <= win_next;
        end
        fwd_reg     <= wdata;
        b_hit_reg   <= b_valid_reg && (b_col_reg == col_b);
        b_col_reg   <= col_b;
        b_px_reg    <= s_tdata;
        b_rowok_reg <= row_ok;
        b_colok_reg <= col_ok;
        b_last_reg  <= last;
    end

    always_comb begin
        push            = b_valid_reg && b_emit_reg;
        push_job.win    = win_next;
        push_job.row_ok = b_rowok_reg;
        push_job.col_ok = b_colok_reg;
        push_job.last   = b_last_reg;
    end

endmodule
`default_nettype wire

### rtl/gb5_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module gb5_fifo (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire gb5_pkg::job_t             push_job,
    input  wire logic                      pop,
    output logic                           q_valid,
    output gb5_pkg::job_t                  q_job,
    output logic [gb5_pkg::CNT_W-1:0]      q_count
);
    import gb5_pkg::*;

    job_t              store_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    always_comb begin
        q_valid = count_reg != '0;
        q_job   = store_reg[rd_ptr_reg];
        q_count = count_reg;
        do_pop  = pop && q_valid;
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

### rtl/gb5_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gb5_back #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire gb5_pkg::job_t      q_job,
    output logic                    q_pop,
    input  wire gb5_pkg::weights_t  weights,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,
    output logic                    m_tlast
);
    import gb5_pkg::*;

    function automatic logic [2:0] pick(input int idx, input logic [3:0] ok);
        case (idx)
            0: return ok[0] ? 3'd0 : 3'd2;
            1: return ok[1] ? 3'd1 : 3'd2;
            3: return ok[2] ? 3'd3 : 3'd2;
            4: return ok[3] ? 3'd4 : 3'd2;
            default: return 3'd2;
        endcase
    endfunction

    logic [PROD_W-1:0]   prod_reg [TAPS][TAPS][NUM_CH];
    logic [PROD_W-1:0]   prod     [TAPS][TAPS][NUM_CH];
    logic [ROWSUM_W-1:0] rsum_reg [TAPS][NUM_CH];
    logic [ROWSUM_W-1:0] rsum     [TAPS][NUM_CH];
    logic                s1_valid_reg, s1_last_reg, s2_valid_reg, s2_last_reg;
    logic                out_valid_reg, out_last_reg;
    logic [23:0]         out_data_reg, out_data;
    logic                en;

    always_comb begin
        en    = !out_valid_reg || m_tready;
        q_pop = en && q_valid;
    end

    always_comb begin
        for (int r = 0; r < TAPS; r++) begin
            for (int c = 0; c < TAPS; c++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    prod[r][c][ch] =
                        PROD_W'(q_job.win[pick(c, q_job.col_ok)][pick(r, q_job.row_ok)]
                                [CH_W*ch +: CH_W])
                        * PROD_W'(weights[weight_class(r, c)]);
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < TAPS; r++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                rsum[r][ch] = '0;
                for (int c = 0; c < TAPS; c++) begin
                    rsum[r][ch] = rsum[r][ch] + ROWSUM_W'(prod_reg[r][c][ch]);
                end
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] tot;
        logic [SUM_W-1:0] sh;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tot = '0;
            for (int r = 0; r < TAPS; r++) begin
                tot = tot + SUM_W'(rsum_reg[r][ch]);
            end
            sh = tot >> WEIGHT_FRAC_BITS;
            out_data[CH_W*ch +: CH_W] = (|sh[SUM_W-1:CH_W]) ? {CH_W{1'b1}} : sh[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg     <= prod;
            s1_last_reg  <= q_job.last;
            rsum_reg     <= rsum;
            s2_last_reg  <= s1_last_reg;
            out_data_reg <= out_data;
            out_last_reg <= s2_last_reg;
        end
    end

    always_comb begin
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tlast  = out_last_reg;
    end

endmodule
`default_nettype wire

### rtl/gaussian_blur_5x5_rgb_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Content
// s_       | in        | tdata: blue, green, red from bit 0; tuser: mode (1 = flush)
// m_       | out       | tdata: blue, green, red from bit 0; tlast: last pixel of frame
// cfg_     | in        | write enable, register index, write data
// One pixel or flush transfer is taken per cycle while the queue has room and no flush
// is held back; the line memory is read and written once per item, with a registered
// read and a write forward for narrow frames. A flush on a frame with fewer pixels than
// 2*W+2 is held back while the window advances internally. Reset needs no clearing pass
// over the line memory. A four-entry queue lets pixel intake go on while the output side
// stalls. A result passes the queue and the product, row-sum and output registers.
module gaussian_blur_5x5_rgb_unit #(
    parameter int MAX_WIDTH        = 1024,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [23:0]                      s_tdata,   // blue, green, red
    input  wire logic                             s_tuser,   // mode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [23:0]                           m_tdata,   // blue, green, red
    output logic                                  m_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [gb5_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gb5_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import gb5_pkg::*;

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    weights_t         weights_reg;
    logic             push, q_valid, q_pop;
    job_t             push_job, q_job;
    logic [CNT_W-1:0] q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg                  <= FRAME_WIDTH_RST;
            height_reg                 <= FRAME_HEIGHT_RST;
            weights_reg[WC_CENTER]     <= W_CENTER_RST;
            weights_reg[WC_NEAR_EDGE]  <= W_NEAR_EDGE_RST;
            weights_reg[WC_NEAR_DIAG]  <= W_NEAR_DIAG_RST;
            weights_reg[WC_FAR_EDGE]   <= W_FAR_EDGE_RST;
            weights_reg[WC_KNIGHT]     <= W_KNIGHT_RST;
            weights_reg[WC_FAR_CORNER] <= W_FAR_CORNER_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:       width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT:      height_reg <= cfg_wdata[FH_W-1:0];
                REG_WEIGHT_CENTER:     weights_reg[WC_CENTER]     <= cfg_wdata;
                REG_WEIGHT_NEAR_EDGE:  weights_reg[WC_NEAR_EDGE]  <= cfg_wdata;
                REG_WEIGHT_NEAR_DIAG:  weights_reg[WC_NEAR_DIAG]  <= cfg_wdata;
                REG_WEIGHT_FAR_EDGE:   weights_reg[WC_FAR_EDGE]   <= cfg_wdata;
                REG_WEIGHT_KNIGHT:     weights_reg[WC_KNIGHT]     <= cfg_wdata;
                REG_WEIGHT_FAR_CORNER: weights_reg[WC_FAR_CORNER] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gb5_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_width (width_reg),
        .cfg_height(height_reg),
        .q_count   (q_count),
        .push      (push),
        .push_job  (push_job)
    );

    gb5_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (q_pop),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_count (q_count)
    );

    gb5_back #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .weights (weights_reg),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import gb5_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int WIDTH_LIMIT = 1024;
    localparam int IDLE_LIMIT  = 20000;
    localparam int SETTLE      = 2 * WIDTH_LIMIT + 64;

    typedef struct {
        bit       flush;
        bit [7:0] blue;
        bit [7:0] green;
        bit [7:0] red;
    } pixel_item_t;

    typedef struct {
        bit [7:0] blue;
        bit [7:0] green;
        bit [7:0] red;
        bit       last;
    } blurred_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    gaussian_blur_5x5_rgb_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pixel_item_t pending_pixels[$];
    blurred_t    expected_pixels[$];
    int          fail_count = 0;
    int          sent_items = 0;

    // Register copies and frame state of the blur.
    bit [10:0] reg_width = 11'd640;
    bit [12:0] reg_height = 13'd480;
    bit [15:0] weights[NUM_WCLASS];
    int unsigned in_col, in_row, out_col, out_row, lat_w, lat_h;
    bit          draining;
    bit [23:0]   frame_pixels[int unsigned];

    function automatic int unsigned weight_of(int dr, int dc);
        int d;
        d = dr * dr + dc * dc;
        case (d)
            0: return weights[WC_CENTER];
            1: return weights[WC_NEAR_EDGE];
            2: return weights[WC_NEAR_DIAG];
            4: return weights[WC_FAR_EDGE];
            5: return weights[WC_KNIGHT];
            default: return weights[WC_FAR_CORNER];
        endcase
    endfunction

    function automatic void latch_frame_size();
        lat_w = reg_width;
        if (lat_w < 1) lat_w = 1;
        if (lat_w > WIDTH_LIMIT) lat_w = WIDTH_LIMIT;
        lat_h = reg_height;
        if (lat_h < 1) lat_h = 1;
        if (lat_h > HEIGHT_LIMIT) lat_h = HEIGHT_LIMIT;
    endfunction

    function automatic blurred_t blur_next_pixel();
        blurred_t res;
        longint unsigned acc[3];
        longint unsigned v;
        int r, c;
        int unsigned j, total, wt;
        bit [23:0] px;
        acc = '{0, 0, 0};
        total = lat_w * lat_h;
        j = out_row * lat_w + out_col;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                r = int'(out_row) + dr;
                c = int'(out_col) + dc;
                if (r < 0 || r >= int'(lat_h)) r = out_row;
                if (c < 0 || c >= int'(lat_w)) c = out_col;
                px = frame_pixels[r * lat_w + c];
                wt = weight_of(dr, dc);
                for (int ch = 0; ch < 3; ch++) acc[ch] += px[8*ch +: 8] * wt;
            end
        end
        v = acc[0] >> FRAC_BITS; res.blue  = v > 255 ? 8'd255 : v[7:0];
        v = acc[1] >> FRAC_BITS; res.green = v > 255 ? 8'd255 : v[7:0];
        v = acc[2] >> FRAC_BITS; res.red   = v > 255 ? 8'd255 : v[7:0];
        res.last = (j == total - 1);
        out_col++;
        if (out_col >= lat_w) begin
            out_col = 0;
            out_row++;
        end
        if (j + 1 >= total) draining = 1'b0;
        return res;
    endfunction

    function automatic void predict_blur(pixel_item_t it);
        int unsigned k;
        if (it.flush) begin
            if (!draining) return;
            if (out_row * lat_w + out_col >= lat_w * lat_h) begin
                draining = 1'b0;
                return;
            end
            expected_pixels.push_back(blur_next_pixel());
            return;
        end
        if (in_col == 0 && in_row == 0) begin
            latch_frame_size();
            out_col = 0;
            out_row = 0;
            draining = 1'b0;
            frame_pixels.delete();
        end
        k = in_row * lat_w + in_col;
        frame_pixels[k] = {it.red, it.green, it.blue};
        in_col++;
        if (in_col >= lat_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= lat_h) begin
                in_row = 0;
                draining = 1'b1;
            end
        end
        if (k >= 2 * lat_w + 2) expected_pixels.push_back(blur_next_pixel());
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    bit s_accepted = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    pixel_item_t next_item;

    always @(posedge aclk) begin
        s_accepted <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            next_item.flush = s_tuser;
            next_item.blue  = s_tdata[7:0];
            next_item.green = s_tdata[15:8];
            next_item.red   = s_tdata[23:16];
            predict_blur(next_item);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (s_accepted || !s_tvalid)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                next_item = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_item.flush;
                s_tdata  <= {next_item.red, next_item.green, next_item.blue};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall probability changes every so often, zero included.
    int stall_pct = 0;
    int stall_hold = 0;
    always @(negedge aclk) begin
        if (stall_hold == 0) begin
            stall_hold <= $urandom_range(20, 300);
            case ($urandom_range(0, 4))
                0, 1: stall_pct <= 0;
                2: stall_pct <= 30;
                3: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end else begin
            stall_hold <= stall_hold - 1;
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    blurred_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected transfer: tdata=%h tlast=%b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[7:0] !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, m_tdata[23:16]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("frame_last: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we ||
            (pending_pixels.size() == 0 && !s_tvalid && expected_pixels.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:       reg_width  = value[10:0];
            REG_FRAME_HEIGHT:      reg_height = value[12:0];
            REG_WEIGHT_CENTER:     weights[WC_CENTER]     = value[15:0];
            REG_WEIGHT_NEAR_EDGE:  weights[WC_NEAR_EDGE]  = value[15:0];
            REG_WEIGHT_NEAR_DIAG:  weights[WC_NEAR_DIAG]  = value[15:0];
            REG_WEIGHT_FAR_EDGE:   weights[WC_FAR_EDGE]   = value[15:0];
            REG_WEIGHT_KNIGHT:     weights[WC_KNIGHT]     = value[15:0];
            default:               weights[WC_FAR_CORNER] = value[15:0];
        endcase
    endtask

    task automatic write_weights(input int unsigned c, ne, nd, fe, kn, fc);
        write_reg(REG_WEIGHT_CENTER, c);
        write_reg(REG_WEIGHT_NEAR_EDGE, ne);
        write_reg(REG_WEIGHT_NEAR_DIAG, nd);
        write_reg(REG_WEIGHT_FAR_EDGE, fe);
        write_reg(REG_WEIGHT_KNIGHT, kn);
        write_reg(REG_WEIGHT_FAR_CORNER, fc);
    endtask

    task automatic push_item(input bit flush, input bit [7:0] b, g, r);
        pixel_item_t it;
        it.flush = flush;
        it.blue  = b;
        it.green = g;
        it.red   = r;
        pending_pixels.push_back(it);
        sent_items++;
    endtask

    task automatic push_random_pixel();
        push_item(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        wait (pending_pixels.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One frame of w x h (latched sizes), with stray flushes inside and a full or partial drain after it.
    task automatic push_frame(input int unsigned w, input int unsigned h, input bit full_drain);
        int unsigned n;
        for (int unsigned i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            push_random_pixel();
        end
        n = full_drain ? 2 * w + 2 + $urandom_range(0, 2) : $urandom_range(0, 2 * w + 1);
        for (int unsigned i = 0; i < n; i++)
            push_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    int unsigned w_reg, h_reg, w_eff, h_eff, nframes;

    initial begin
        weights[WC_CENTER]     = W_CENTER_RST;
        weights[WC_NEAR_EDGE]  = W_NEAR_EDGE_RST;
        weights[WC_NEAR_DIAG]  = W_NEAR_DIAG_RST;
        weights[WC_FAR_EDGE]   = W_FAR_EDGE_RST;
        weights[WC_KNIGHT]     = W_KNIGHT_RST;
        weights[WC_FAR_CORNER] = W_FAR_CORNER_RST;
        reg_width  = FRAME_WIDTH_RST;
        reg_height = FRAME_HEIGHT_RST;
        latch_frame_size();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Saturating sums on a single-pixel frame, idle and extra flushes.
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        write_weights(65535, 65535, 65535, 65535, 65535, 65535);
        push_item(1'b1, 8'hff, 8'hff, 8'hff);
        push_item(1'b0, 8'hff, 8'hff, 8'hff);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b0, 8'h00, 8'h00, 8'h00);
        push_item(1'b1, 8'hff, 8'hff, 8'hff);
        wait_idle();

        // Small frame with an early flush, a partial drain, then a new frame.
        write_reg(REG_FRAME_WIDTH, 2);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_weights(0, 0, 0, 0, 0, 0);
        write_weights(13168, 7005, 3726, 1054, 561, 84);
        push_item(1'b0, 8'hff, 8'h00, 8'hff);
        push_item(1'b0, 8'h00, 8'hff, 8'h00);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b0, 8'hff, 8'hff, 8'hff);
        push_item(1'b0, 8'h00, 8'h00, 8'h00);
        push_item(1'b0, 8'h80, 8'h7f, 8'h01);
        push_item(1'b0, 8'hfe, 8'h55, 8'haa);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b0, 8'h12, 8'h34, 8'h56);
        for (int i = 0; i < 5; i++) push_random_pixel();
        for (int i = 0; i < 7; i++) push_item(1'b1, 8'h00, 8'h00, 8'h00);
        wait_idle();

        // Widest frame with a partial drain; the frame height is driven to its top value first.
        write_reg(REG_FRAME_WIDTH, 2047);
        write_reg(REG_FRAME_HEIGHT, 8191);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_weights($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
        for (int i = 0; i < WIDTH_LIMIT; i++) push_random_pixel();
        for (int i = 0; i < 40; i++) push_item(1'b1, 8'h00, 8'h00, 8'h00);
        wait_idle();

        while (sent_items < 1350) begin
            w_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) % 16
                                                : $urandom_range(1, 12);
            h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            write_reg(REG_FRAME_WIDTH, w_reg);
            write_reg(REG_FRAME_HEIGHT, h_reg);
            if ($urandom_range(0, 3) == 0)
                write_weights(65535, 0, 65535, 0, 65535, 0);
            else
                write_weights($urandom_range(0, 16000), $urandom_range(0, 16000),
                              $urandom_range(0, 16000), $urandom_range(0, 8000),
                              $urandom_range(0, 8000), $urandom_range(0, 65535));
            w_eff = (w_reg == 0) ? 1 : w_reg;
            h_eff = (h_reg == 0) ? 1 : h_reg;
            nframes = $urandom_range(1, 3);
            for (int unsigned f = 0; f < nframes; f++)
                push_frame(w_eff, h_eff, (f == nframes - 1) || ($urandom_range(0, 3) != 0));
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
